// ----- rtl/assert_macros.svh -----
// shared assertion macros for the rle8 decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rle8 assertion failed");

// next-cycle implication
`define RLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rle8 assertion failed");

`endif

// ----- rtl/rle8_pkg.sv -----
`default_nettype none

package rle8_pkg;

  localparam int DimW = 13;

  typedef logic [0:0] cfg_addr_t;
  typedef logic [DimW-1:0] dim_t;

  localparam cfg_addr_t REG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_addr_t REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_VALUE  = 3'd1,
    PH_ESCAPE = 3'd2,
    PH_DX     = 3'd3,
    PH_DY     = 3'd4,
    PH_ABS    = 3'd5,
    PH_PAD    = 3'd6
  } phase_e;

  typedef struct packed {
    logic [11:0] span_x;
    logic [11:0] span_line;
    logic [7:0]  span_length;
    logic [7:0]  pixel_value;
    logic        end_of_bitmap;
    logic        clipped;
  } span_t;

  function automatic dim_t sat13(input logic [DimW:0] v);
    sat13 = v[DimW] ? '1 : v[DimW-1:0];
  endfunction

  function automatic logic [11:0] sat12(input dim_t v);
    sat12 = v[12] ? 12'hFFF : v[11:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rle8_bitmap_decoder.sv -----
`default_nettype none

// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// data in  | data_valid_i / data_ready_o | data_byte_i, last_in_buffer_i
// span out | span_valid_o / span_ready_i | span_x_o, span_line_o, span_length_o,
//          |                            | pixel_value_o, end_of_bitmap_o, clipped_o
// config   | cfg_we_i                   | cfg_addr_i, cfg_wdata_i
//
// one byte per cycle when ready; a byte waits in the byte register until the span
// register is free, then any span it yields is loaded there; each holds one item, so
// a byte can be taken while a span waits, and a span stall backs up through the byte
// register; async active-low reset restores parser, config and valid flags

module rle8_bitmap_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire rle8_pkg::cfg_addr_t cfg_addr_i,
  input  wire rle8_pkg::dim_t      cfg_wdata_i,
  input  wire logic                data_valid_i,
  output logic                     data_ready_o,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                last_in_buffer_i,
  output logic                     span_valid_o,
  input  wire logic                span_ready_i,
  output logic [11:0]              span_x_o,
  output logic [11:0]              span_line_o,
  output logic [7:0]               span_length_o,
  output logic [7:0]               pixel_value_o,
  output logic                     end_of_bitmap_o,
  output logic                     clipped_o
);
  import rle8_pkg::*;

  `include "assert_macros.svh"

  localparam int WTop = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int HTop = (MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096;
  localparam logic [12:0] WidthTop  = 13'(WTop);
  localparam logic [12:0] HeightTop = 13'(HTop);

  dim_t       width, height;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  span_t      out_q;
  logic       out_free, in_fire, stage_fire, res_valid;
  span_t      res;

  rle8_cfg #(
    .WIDTH_TOP  (WidthTop),
    .HEIGHT_TOP (HeightTop)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (cfg_we_i),
    .addr_i   (cfg_addr_i),
    .wdata_i  (cfg_wdata_i),
    .width_o  (width),
    .height_o (height)
  );

  assign out_free     = !out_valid_q || span_ready_i;
  assign stage_fire   = in_valid_q && out_free;
  assign data_ready_o = !in_valid_q || out_free;
  assign in_fire      = data_valid_i && data_ready_o;

  rle8_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (stage_fire),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .width_i     (width),
    .height_i    (height),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (stage_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_in_buffer_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (span_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign span_valid_o    = out_valid_q;
  assign span_x_o        = out_q.span_x;
  assign span_line_o     = out_q.span_line;
  assign span_length_o   = out_q.span_length;
  assign pixel_value_o   = out_q.pixel_value;
  assign end_of_bitmap_o = out_q.end_of_bitmap;
  assign clipped_o       = out_q.clipped;

  `RLE_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, data_ready_o)
  `RLE_ASSERT_NXT(a_span_loaded, clk_i, rst_ni, stage_fire && res_valid, span_valid_o)
  `RLE_ASSERT_NXT(a_span_held, clk_i, rst_ni, span_valid_o && !span_ready_i, span_valid_o)

endmodule

`default_nettype wire

// ----- rtl/rle8_cfg.sv -----
`default_nettype none

module rle8_cfg #(
  parameter logic [12:0] WIDTH_TOP  = 13'd4096,
  parameter logic [12:0] HEIGHT_TOP = 13'd4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               we_i,
  input  wire rle8_pkg::cfg_addr_t addr_i,
  input  wire rle8_pkg::dim_t     wdata_i,
  output rle8_pkg::dim_t          width_o,
  output rle8_pkg::dim_t          height_o
);
  import rle8_pkg::*;

  dim_t width_q, height_q;

  // registers hold the clamped value, not the raw write
  function automatic dim_t clamp_dim(input dim_t v, input dim_t top);
    if (v == '0) begin
      clamp_dim = dim_t'(1);
    end else if (v > top) begin
      clamp_dim = top;
    end else begin
      clamp_dim = v;
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dim_t'(1);
      height_q <= dim_t'(1);
    end else if (we_i) begin
      case (addr_i)
        REG_IMAGE_WIDTH:  width_q  <= clamp_dim(wdata_i, WIDTH_TOP);
        REG_IMAGE_HEIGHT: height_q <= clamp_dim(wdata_i, HEIGHT_TOP);
        default: ;
      endcase
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;

endmodule

`default_nettype wire

// ----- rtl/rle8_parser.sv -----
`default_nettype none

module rle8_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           last_i,
  input  wire rle8_pkg::dim_t width_i,
  input  wire rle8_pkg::dim_t height_i,
  output logic                res_valid_o,
  output rle8_pkg::span_t     res_o
);
  import rle8_pkg::*;

  `include "assert_macros.svh"

  phase_e     phase_q, phase_d;
  logic [7:0] run_q, run_d;
  dim_t       col_q, col_d, col_nx;
  dim_t       line_q, line_d, line_nx;
  logic [7:0] abs_q, abs_d, abs_nx;
  logic       pad_q, pad_d, pad_nx;
  logic [7:0] dx_q, dx_d, dx_nx;
  logic       done_q, done_d, done_nx;
  logic [7:0] run_nx;

  logic        span_en, close_en;
  logic [7:0]  span_len, span_val, span_out_len;
  logic        span_clip;
  logic [13:0] span_end;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (!done_q) begin
      case (phase_q)
        PH_VALUE: phase_d = PH_COUNT;
        PH_ESCAPE: begin
          if (byte_i == ESC_EOL || byte_i == ESC_EOB) begin
            phase_d = PH_COUNT;
          end else if (byte_i == ESC_DELTA) begin
            phase_d = PH_DX;
          end else begin
            phase_d = PH_ABS;
          end
        end
        PH_DX: phase_d = PH_DY;
        PH_DY: phase_d = PH_COUNT;
        PH_ABS: begin
          if (abs_q == 8'd1) begin
            phase_d = pad_q ? PH_PAD : PH_COUNT;
          end
        end
        PH_PAD: phase_d = PH_COUNT;
        default: phase_d = (byte_i != 8'd0) ? PH_VALUE : PH_ESCAPE;
      endcase
    end
    if (last_i) begin
      phase_d = PH_COUNT;
    end
  end

  // datapath and span decode
  always_comb begin
    run_nx   = run_q;
    col_nx   = col_q;
    line_nx  = line_q;
    abs_nx   = abs_q;
    pad_nx   = pad_q;
    dx_nx    = dx_q;
    done_nx  = done_q;
    span_en  = 1'b0;
    close_en = 1'b0;
    span_len = 8'd0;
    span_val = 8'd0;
    if (!done_q) begin
      case (phase_q)
        PH_VALUE: begin
          span_en  = 1'b1;
          span_len = run_q;
          span_val = byte_i;
        end
        PH_ESCAPE: begin
          if (byte_i == ESC_EOL) begin
            col_nx  = '0;
            line_nx = sat13({1'b0, line_q} + 14'd1);
          end else if (byte_i == ESC_EOB) begin
            close_en = 1'b1;
            done_nx  = 1'b1;
          end else if (byte_i != ESC_DELTA) begin
            abs_nx = byte_i;
            pad_nx = byte_i[0];
          end
        end
        PH_DX: dx_nx = byte_i;
        PH_DY: begin
          col_nx  = sat13({1'b0, col_q} + 14'(dx_q));
          line_nx = sat13({1'b0, line_q} + 14'(byte_i));
        end
        PH_ABS: begin
          span_en  = 1'b1;
          span_len = 8'd1;
          span_val = byte_i;
          abs_nx   = abs_q - 8'd1;
        end
        PH_PAD: pad_nx = 1'b0;
        default: begin
          if (byte_i != 8'd0) begin
            run_nx = byte_i;
          end
        end
      endcase
    end

    // clip against the image and advance the column
    span_end = {1'b0, col_q} + 14'(span_len);
    if (line_q >= height_i || col_q >= width_i) begin
      span_out_len = 8'd0;
      span_clip    = 1'b1;
    end else if (span_end > {1'b0, width_i}) begin
      span_out_len = 8'(width_i - col_q);
      span_clip    = 1'b1;
    end else begin
      span_out_len = span_len;
      span_clip    = 1'b0;
    end
    if (span_en) begin
      col_nx = sat13(span_end);
    end
  end

  // result and state with buffer-end clear
  always_comb begin
    res_valid_o         = span_en || close_en || (last_i && !done_q);
    res_o.span_x        = span_en ? sat12(col_q) : sat12(col_nx);
    res_o.span_line     = sat12(line_nx);
    res_o.span_length   = span_en ? span_out_len : 8'd0;
    res_o.pixel_value   = span_en ? span_val : 8'd0;
    res_o.clipped       = span_en && span_clip;
    res_o.end_of_bitmap = close_en || (last_i && !done_q);

    run_d  = last_i ? 8'd0 : run_nx;
    col_d  = last_i ? '0 : col_nx;
    line_d = last_i ? '0 : line_nx;
    abs_d  = last_i ? 8'd0 : abs_nx;
    pad_d  = last_i ? 1'b0 : pad_nx;
    dx_d   = last_i ? 8'd0 : dx_nx;
    done_d = last_i ? 1'b0 : done_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      run_q   <= 8'd0;
      col_q   <= '0;
      line_q  <= '0;
      abs_q   <= 8'd0;
      pad_q   <= 1'b0;
      dx_q    <= 8'd0;
      done_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      col_q   <= col_d;
      line_q  <= line_d;
      abs_q   <= abs_d;
      pad_q   <= pad_d;
      dx_q    <= dx_d;
      done_q  <= done_d;
    end
  end

  `RLE_ASSERT_IMP(a_silent_after_end, clk_i, rst_ni,
    fire_i && done_q && !last_i, !res_valid_o)
  `RLE_ASSERT_NXT(a_last_clears, clk_i, rst_ni,
    fire_i && last_i, phase_q == PH_COUNT && !done_q && col_q == '0 && line_q == '0)
  `RLE_ASSERT_IMP(a_span_in_width, clk_i, rst_ni,
    fire_i && res_valid_o && res_o.span_length != 8'd0,
    ({1'b0, col_q} + 14'(res_o.span_length)) <= {1'b0, width_i})

endmodule

`default_nettype wire
